// ===== rtl/core/sawc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sawc_pkg;

	// Cache geometry
	localparam int NUM_WAYS        = 8;
	localparam int NUM_SET_ROWS    = 64;
	localparam int LINE_BYTE_COUNT = 64;
	localparam int ADDRESS_BITS    = 20;
	localparam int WORD_BYTES      = 8;

	localparam int OFFSET_W  = $clog2(LINE_BYTE_COUNT);
	localparam int SET_W     = $clog2(NUM_SET_ROWS);
	localparam int TAG_W     = ADDRESS_BITS - OFFSET_W - SET_W;
	localparam int LINE_W    = ADDRESS_BITS - OFFSET_W;
	localparam int WAY_W     = $clog2(NUM_WAYS);
	localparam int AGE_W     = $clog2(NUM_WAYS);
	localparam int BYTE_W    = $clog2(WORD_BYTES);
	localparam int BEATS     = LINE_BYTE_COUNT / WORD_BYTES;
	localparam int BEAT_W    = $clog2(BEATS);
	localparam int WORD_W    = WORD_BYTES * 8;
	localparam int BACK_AW   = LINE_W + BEAT_W;
	localparam int BACK_D    = 1 << BACK_AW;
	localparam int DATA_AW   = SET_W + WAY_W + BEAT_W;
	localparam int DATA_D    = 1 << DATA_AW;
	localparam int CNT_W     = 32;

	// Per-way tag state
	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} way_meta_t;

	typedef way_meta_t [NUM_WAYS-1:0] meta_row_t;

	localparam int META_W = $bits(meta_row_t);

	// Controller to datapath
	typedef struct packed {
		logic ready;
		logic accept;
		logic clear_step;
		logic lookup;
		logic wb_step;
		logic fill_step;
		logic access;
		logic finish;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic hit;
		logic need_wb;
		logic beats_done;
		logic out_free;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/set_assoc_writeback_cache_core.sv =====
// A read or write hit goes from the input transfer through LOOKUP, ACCESS and DATA to the
// registered result; DATA waits while the output is held. A miss adds a line fill, and a
// dirty victim a writeback before it, each one 64-bit word per cycle through the memories.
// One item at a time: a new input is taken only after the last result is loaded for output.
// Reset: asynchronous; after reset all 131072 words of the backing memory are swept to
// zero, one word a cycle, during which no input transfer is taken.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_writeback_cache_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,  // address[19:0], write_data[27:20], zero pad
	input  wire logic [0:0]   s_axis_tuser,  // action[0]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [111:0]      m_axis_tdata   // read_data[7:0], hit[8], wrote_back[9],
	                                         // hit_count[41:10], miss_count[73:42],
	                                         // writeback_count[105:74], zero pad
);

	sawc_pkg::ctl_cmd_t cmd;
	sawc_pkg::ctl_sts_t sts;

	logic [7:0]                 rd;
	logic                       hit, wb;
	logic [sawc_pkg::CNT_W-1:0] hc, mc, wc;

	sawc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .sts(sts), .cmd(cmd)
	);

	sawc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(s_axis_tuser[0]),
		.in_address(s_axis_tdata[sawc_pkg::ADDRESS_BITS-1:0]),
		.in_wdata(s_axis_tdata[27:20]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_read_data(rd), .out_hit(hit), .out_wrote_back(wb),
		.out_hit_count(hc), .out_miss_count(mc), .out_wb_count(wc)
	);

	assign s_axis_tready = cmd.ready;
	assign m_axis_tdata  = {6'd0, wc, mc, hc, wb, hit, rd};

	// One item in flight: a transfer closes the input side
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// A hit never writes back
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
		else $error("writeback reported on a hit");

	// A writeback is counted
	a_wb_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[105:74] != '0)
		else $error("writeback not counted");

endmodule

`default_nettype wire

// ===== rtl/core/sawc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sawc_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/sawc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sawc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire sawc_pkg::ctl_sts_t sts,
	output sawc_pkg::ctl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_FILL,
		ST_ACCESS,
		ST_DATA
	} state_t;

	state_t state_q;

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR:  if (sts.clear_done) state_q <= ST_IDLE;
				ST_IDLE:   if (in_valid) state_q <= ST_LOOKUP;
				ST_LOOKUP: begin
					if (sts.hit)          state_q <= ST_ACCESS;
					else if (sts.need_wb) state_q <= ST_WB;
					else                  state_q <= ST_FILL;
				end
				ST_WB:     if (sts.beats_done) state_q <= ST_FILL;
				ST_FILL:   if (sts.beats_done) state_q <= ST_ACCESS;
				ST_ACCESS: state_q <= ST_DATA;
				ST_DATA:   if (sts.out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_CLEAR;
			endcase
		end
	end

	// Decode commands from state
	always_comb begin
		cmd            = '0;
		cmd.ready      = (state_q == ST_IDLE);
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.clear_step = (state_q == ST_CLEAR);
		cmd.lookup     = (state_q == ST_LOOKUP);
		cmd.wb_step    = (state_q == ST_WB);
		cmd.fill_step  = (state_q == ST_FILL);
		cmd.access     = (state_q == ST_ACCESS) || (state_q == ST_DATA);
		cmd.finish     = (state_q == ST_DATA) && sts.out_free;
	end

endmodule

`default_nettype wire

// ===== rtl/core/sawc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sawc_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sawc_pkg::ctl_cmd_t                cmd,
	output sawc_pkg::ctl_sts_t                     sts,
	input  wire logic                              in_action,
	input  wire logic [sawc_pkg::ADDRESS_BITS-1:0] in_address,
	input  wire logic [7:0]                        in_wdata,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             out_read_data,
	output logic                                   out_hit,
	output logic                                   out_wrote_back,
	output logic [sawc_pkg::CNT_W-1:0]             out_hit_count,
	output logic [sawc_pkg::CNT_W-1:0]             out_miss_count,
	output logic [sawc_pkg::CNT_W-1:0]             out_wb_count
);

	localparam int NW = sawc_pkg::NUM_WAYS;

	// Request registers
	logic                              op_q;
	logic [sawc_pkg::ADDRESS_BITS-1:0] addr_q;
	logic [7:0]                        wdata_q;

	// Lookup outcome, beat and sweep counters, set valid bits and totals
	logic                           hit_q;
	logic                           wb_q;
	logic [sawc_pkg::WAY_W-1:0]     way_q;
	logic [sawc_pkg::TAG_W-1:0]     vtag_q;
	logic [sawc_pkg::BEAT_W:0]      beat_q;
	logic [sawc_pkg::BACK_AW-1:0]   clr_q;
	logic [sawc_pkg::NUM_SET_ROWS-1:0] rvalid_q;
	logic [sawc_pkg::CNT_W-1:0]     hit_cnt_q, miss_cnt_q, wb_cnt_q;

	// Address fields
	logic [sawc_pkg::SET_W-1:0]  set_a;
	logic [sawc_pkg::TAG_W-1:0]  tag_a;
	logic [sawc_pkg::LINE_W-1:0] line_a;
	logic [sawc_pkg::BEAT_W-1:0] word_a;
	logic [sawc_pkg::BYTE_W-1:0] bsel_a;
	logic [sawc_pkg::SET_W-1:0]  set_in;

	assign set_in = in_address[sawc_pkg::OFFSET_W +: sawc_pkg::SET_W];
	assign set_a  = addr_q[sawc_pkg::OFFSET_W +: sawc_pkg::SET_W];
	assign tag_a  = addr_q[sawc_pkg::ADDRESS_BITS-1 -: sawc_pkg::TAG_W];
	assign line_a = addr_q[sawc_pkg::ADDRESS_BITS-1 -: sawc_pkg::LINE_W];
	assign word_a = addr_q[sawc_pkg::BYTE_W +: sawc_pkg::BEAT_W];
	assign bsel_a = addr_q[sawc_pkg::BYTE_W-1:0];

	// Memories
	logic [sawc_pkg::META_W-1:0]  meta_rdata;
	sawc_pkg::meta_row_t          row, new_row;
	logic                         meta_we;

	logic                         data_we;
	logic [sawc_pkg::DATA_AW-1:0] data_waddr, data_raddr;
	logic [sawc_pkg::WORD_W-1:0]  data_wdata, data_rdata;

	logic                         back_we;
	logic [sawc_pkg::BACK_AW-1:0] back_waddr, back_raddr;
	logic [sawc_pkg::WORD_W-1:0]  back_wdata, back_rdata;

	sawc_ram #(.W(sawc_pkg::META_W), .D(sawc_pkg::NUM_SET_ROWS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(set_a), .wdata(new_row),
		.raddr(set_in), .rdata(meta_rdata)
	);

	sawc_ram #(.W(sawc_pkg::WORD_W), .D(sawc_pkg::DATA_D)) u_data (
		.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
		.raddr(data_raddr), .rdata(data_rdata)
	);

	sawc_ram #(.W(sawc_pkg::WORD_W), .D(sawc_pkg::BACK_D)) u_back (
		.clk(clk), .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
		.raddr(back_raddr), .rdata(back_rdata)
	);

	// Tag compare, victim choice and recency update
	logic                       hit_c, inv_c;
	logic [sawc_pkg::WAY_W-1:0] hit_way, inv_way, old_way, sel_way;
	logic [sawc_pkg::AGE_W-1:0] oldest;
	logic [sawc_pkg::AGE_W:0]   old_age;

	always_comb begin
		row     = rvalid_q[set_a] ? sawc_pkg::meta_row_t'(meta_rdata) : '0;
		hit_c   = 1'b0;
		inv_c   = 1'b0;
		hit_way = '0;
		inv_way = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].tag == tag_a) begin
				hit_c   = 1'b1;
				hit_way = sawc_pkg::WAY_W'(w);
			end
			if (!row[w].valid) begin
				inv_c   = 1'b1;
				inv_way = sawc_pkg::WAY_W'(w);
			end
		end
		oldest  = '0;
		old_way = '0;
		for (int w = 0; w < NW; w++) begin
			if (row[w].age > oldest) begin
				oldest  = row[w].age;
				old_way = sawc_pkg::WAY_W'(w);
			end
		end
		sel_way = hit_c ? hit_way : (inv_c ? inv_way : old_way);
		old_age = row[sel_way].valid ? {1'b0, row[sel_way].age}
		                             : (sawc_pkg::AGE_W + 1)'(NW);
		new_row = row;
		for (int w = 0; w < NW; w++) begin
			if (row[w].valid && {1'b0, row[w].age} < old_age) begin
				new_row[w].age = row[w].age + 1'b1;
			end
		end
		new_row[sel_way].valid = 1'b1;
		new_row[sel_way].dirty = (hit_c && row[sel_way].dirty) || op_q;
		new_row[sel_way].tag   = tag_a;
		new_row[sel_way].age   = '0;
	end

	assign meta_we = cmd.lookup;

	// Status to controller
	assign sts.clear_done = (clr_q == '1);
	assign sts.hit        = hit_c;
	assign sts.need_wb    = !hit_c && row[sel_way].valid && row[sel_way].dirty;
	assign sts.beats_done = (beat_q == (sawc_pkg::BEAT_W + 1)'(sawc_pkg::BEATS));
	assign sts.out_free   = !out_valid || out_ready;

	// Line transfer addressing
	logic [sawc_pkg::BEAT_W-1:0] beat_lo, beat_prev;
	logic [sawc_pkg::WORD_W-1:0] merged;

	assign beat_lo   = beat_q[sawc_pkg::BEAT_W-1:0];
	assign beat_prev = beat_lo - 1'b1;

	always_comb begin
		merged = data_rdata;
		merged[bsel_a * 8 +: 8] = wdata_q;
	end

	always_comb begin
		data_raddr = {set_a, way_q, cmd.access ? word_a : beat_lo};
		back_raddr = {line_a, beat_lo};
		data_we    = 1'b0;
		data_waddr = {set_a, way_q, beat_prev};
		data_wdata = back_rdata;
		back_we    = 1'b0;
		back_waddr = {vtag_q, set_a, beat_prev};
		back_wdata = data_rdata;
		if (cmd.fill_step && beat_q != '0) begin
			data_we = 1'b1;
		end
		if (cmd.finish && op_q) begin
			data_we    = 1'b1;
			data_waddr = {set_a, way_q, word_a};
			data_wdata = merged;
		end
		if (cmd.wb_step && beat_q != '0) begin
			back_we = 1'b1;
		end
		if (cmd.clear_step) begin
			back_we    = 1'b1;
			back_waddr = clr_q;
			back_wdata = '0;
		end
	end

	// Hold the request and the lookup outcome
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_action;
			addr_q  <= in_address;
			wdata_q <= in_wdata;
		end
		if (cmd.lookup) begin
			hit_q  <= hit_c;
			way_q  <= sel_way;
			vtag_q <= row[sel_way].tag;
		end
	end

	// Control state, totals and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q   <= '0;
			clr_q      <= '0;
			beat_q     <= '0;
			wb_q       <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			wb_cnt_q   <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.lookup) begin
				rvalid_q[set_a] <= 1'b1;
				beat_q          <= '0;
				wb_q            <= sts.need_wb;
				if (hit_c) begin
					if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
				end
				if (sts.need_wb && wb_cnt_q != '1) begin
					wb_cnt_q <= wb_cnt_q + 1'b1;
				end
			end
			if (cmd.wb_step || cmd.fill_step) begin
				beat_q <= sts.beats_done ? '0 : beat_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_read_data  <= op_q ? 8'd0 : data_rdata[bsel_a * 8 +: 8];
			out_hit        <= hit_q;
			out_wrote_back <= wb_q;
			out_hit_count  <= hit_cnt_q;
			out_miss_count <= miss_cnt_q;
			out_wb_count   <= wb_cnt_q;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/cache_checker.sv =====
`timescale 1ns / 1ps

module cache_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,
	input  wire logic [0:0]   s_axis_tuser,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [111:0] m_axis_tdata,
	output int                fail_count,
	output int                pending
);

	localparam int SLOTS = sawc_pkg::NUM_SET_ROWS * sawc_pkg::NUM_WAYS;
	localparam int LBC   = sawc_pkg::LINE_BYTE_COUNT;

	typedef struct packed {
		logic [31:0] wb_cnt;
		logic [31:0] miss_cnt;
		logic [31:0] hit_cnt;
		logic        wrote_back;
		logic        hit;
		logic [7:0]  rdata;
	} access_result_t;

	// Cache state shadow
	bit                         valid_q [SLOTS];
	bit                         dirty_q [SLOTS];
	logic [sawc_pkg::TAG_W-1:0] tag_q   [SLOTS];
	int unsigned                age_q   [SLOTS];
	logic [7:0]                 line_data [SLOTS*LBC];
	logic [7:0]                 backing [int unsigned];
	logic [31:0]                hits, misses, wbs;
	access_result_t             expected_results[$];

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Promote way w to most recent; others younger than it age by one
	function automatic void promote(int base, int w);
		int unsigned old_age;
		old_age = valid_q[base+w] ? age_q[base+w] : sawc_pkg::NUM_WAYS;
		for (int i = 0; i < sawc_pkg::NUM_WAYS; i++)
			if (i != w && valid_q[base+i] && age_q[base+i] < old_age)
				age_q[base+i]++;
		age_q[base+w] = 0;
	endfunction

	function automatic access_result_t predict_access(bit is_wr, logic [19:0] addr,
		logic [7:0] wdata);
		access_result_t r;
		int offs, set_idx, base, way, slot;
		int unsigned oldest, vbase, fbase;
		logic [sawc_pkg::TAG_W-1:0] tg;
		r = '0;
		offs = addr[sawc_pkg::OFFSET_W-1:0];
		set_idx = addr[sawc_pkg::OFFSET_W +: sawc_pkg::SET_W];
		tg = addr[19 -: sawc_pkg::TAG_W];
		base = set_idx * sawc_pkg::NUM_WAYS;
		way = -1;
		for (int i = 0; i < sawc_pkg::NUM_WAYS; i++)
			if (way < 0 && valid_q[base+i] && tag_q[base+i] == tg) way = i;
		if (way >= 0) begin
			r.hit = 1;
			hits = sat_inc(hits);
			promote(base, way);
		end else begin
			misses = sat_inc(misses);
			for (int i = sawc_pkg::NUM_WAYS-1; i >= 0; i--)
				if (!valid_q[base+i]) way = i;
			if (way < 0) begin
				oldest = 0;
				way = 0;
				for (int i = 0; i < sawc_pkg::NUM_WAYS; i++)
					if (age_q[base+i] > oldest) begin
						oldest = age_q[base+i];
						way = i;
					end
			end
			slot = base + way;
			if (valid_q[slot] && dirty_q[slot]) begin
				vbase = (int'(tag_q[slot]) * sawc_pkg::NUM_SET_ROWS + set_idx) * LBC;
				for (int i = 0; i < LBC; i++)
					backing[vbase+i] = line_data[slot*LBC+i];
				wbs = sat_inc(wbs);
				r.wrote_back = 1;
			end
			fbase = addr - offs;
			for (int i = 0; i < LBC; i++)
				line_data[slot*LBC+i] =
					backing.exists(fbase+i) ? backing[fbase+i] : 8'h00;
			promote(base, way);
			valid_q[slot] = 1;
			dirty_q[slot] = 0;
			tag_q[slot] = tg;
		end
		slot = base + way;
		if (is_wr) begin
			line_data[slot*LBC+offs] = wdata;
			dirty_q[slot] = 1;
		end else
			r.rdata = line_data[slot*LBC+offs];
		r.hit_cnt = hits;
		r.miss_cnt = misses;
		r.wb_cnt = wbs;
		return r;
	endfunction

	assign pending = expected_results.size();

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		access_result_t exp_r, got;
		if (!arst_n) begin
			fail_count <= 0;
			expected_results.delete();
			backing.delete();
			hits = 0;
			misses = 0;
			wbs = 0;
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] = 0;
				dirty_q[i] = 0;
				tag_q[i] = '0;
				age_q[i] = 0;
			end
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(predict_access(s_axis_tuser[0],
					s_axis_tdata[19:0], s_axis_tdata[27:20]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[105:0];
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer %h", got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.rdata !== exp_r.rdata)
						$error("read_data exp %h got %h", exp_r.rdata, got.rdata);
					if (got.hit !== exp_r.hit)
						$error("hit exp %b got %b", exp_r.hit, got.hit);
					if (got.wrote_back !== exp_r.wrote_back)
						$error("wrote_back exp %b got %b", exp_r.wrote_back, got.wrote_back);
					if (got.hit_cnt !== exp_r.hit_cnt)
						$error("hit_count exp %0d got %0d", exp_r.hit_cnt, got.hit_cnt);
					if (got.miss_cnt !== exp_r.miss_cnt)
						$error("miss_count exp %0d got %0d", exp_r.miss_cnt, got.miss_cnt);
					if (got.wb_cnt !== exp_r.wb_cnt)
						$error("writeback_count exp %0d got %0d", exp_r.wb_cnt, got.wb_cnt);
					if (m_axis_tdata[111:106] !== 6'd0)
						$error("pad exp %h got %h", 6'd0, m_axis_tdata[111:106]);
					if (got !== exp_r || m_axis_tdata[111:106] !== 6'd0)
						fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = '0;
	logic [0:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [111:0] m_axis_tdata;
	int           fail_count, pending;
	int           stall_pct = 0;
	int           idle_cycles = 0;
	logic [19:0]  recent_addr[$];

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	set_assoc_writeback_cache_core dut (.*);

	cache_checker chk (.*);

	// Random receiver stall
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// Watchdog: the idle limit covers the clearing sweep of all 131072 backing words after reset
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 400000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic send_access(bit is_wr, logic [19:0] addr, logic [7:0] wdata,
		int gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= is_wr;
		s_axis_tdata <= {4'd0, wdata, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		recent_addr.push_back(addr);
		if (recent_addr.size() > 24) void'(recent_addr.pop_front());
	endtask

	// Mostly one hot region of sets and tags to force evictions and writebacks
	task automatic send_random(int gap_pct);
		logic [19:0] a;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35 && recent_addr.size() > 0)
			a = recent_addr[$urandom_range(recent_addr.size()-1)] ^ $urandom_range(63);
		else if (pick < 85)
			a = {$urandom_range(15), 6'($urandom_range(3)), 6'($urandom)};
		else
			a = $urandom;
		send_access($urandom_range(1), a, $urandom, gap_pct);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, read and write, fill from cleared memory,
		// LRU over nine tags of one set, dirty writeback and readback
		send_access(0, 20'h00000, 8'h00, 0);
		send_access(1, 20'hFFFFF, 8'hFF, 0);
		send_access(0, 20'hFFFFF, 8'h00, 0);
		send_access(1, 20'h00000, 8'hA5, 0);
		for (int t = 1; t < 9; t++)
			send_access(1, {8'(t), 6'd0, 6'(t)}, 8'(8'h10 + t), 0);
		send_access(0, 20'h00000, 8'h00, 0);
		send_access(0, {8'd1, 6'd0, 6'd1}, 8'h00, 0);
		send_access(1, 20'h5555A, 8'h5A, 0);
		send_access(1, 20'hAAAA5, 8'hC3, 0);
		send_access(0, 20'h5555A, 8'h00, 0);
		drain();
		// Random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			int gap;
			gap = (ph == 1) ? 56 : (ph == 3) ? 20 : 0;
			stall_pct = (ph == 2) ? 56 : (ph == 3) ? 20 : 0;
			for (int n = 0; n < 435; n++)
				send_random(gap);
			drain();
		end
		stall_pct = 0;
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
